/* hw/rtl/xysm_pkg.sv */
// Shared types and constants for the two-axis stepper motion controller.
// Used by xysm_ctrl, xysm_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package xysm_pkg;

   localparam int POS_BITS_DEFAULT = 16;
   localparam int RATE_W           = 16;
   localparam int PERIOD_W         = 20;
   localparam int DIV_NUM_W        = 22;
   localparam int CNT_W            = 6;
   localparam int REQ_DATA_W       = 40;
   localparam int RSP_DATA_W       = 112;

   localparam logic [DIV_NUM_W-1:0] US_PER_SECOND = 22'd1000000;
   localparam logic [DIV_NUM_W-1:0] SPEED_SLOPE   = 22'd50;

   localparam logic [RATE_W-1:0] X_RATE_MAX_RST = 16'd2000;
   localparam logic [RATE_W-1:0] X_RATE_MIN_RST = 16'd100;
   localparam logic [RATE_W-1:0] Y_RATE_MAX_RST = 16'd2000;
   localparam logic [RATE_W-1:0] Y_RATE_MIN_RST = 16'd100;

   // Command codes carried in the request tuser.
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_TARGET = 2'd1;
   localparam logic [1:0] CMD_HOME   = 2'd2;
   localparam logic [1:0] CMD_SPEED  = 2'd3;

   // Register indexes on the csr port.
   localparam logic [1:0] CSR_X_RATE_MAX = 2'd0;
   localparam logic [1:0] CSR_X_RATE_MIN = 2'd1;
   localparam logic [1:0] CSR_Y_RATE_MAX = 2'd2;
   localparam logic [1:0] CSR_Y_RATE_MIN = 2'd3;

   // Operand selection for the shared divider.
   localparam logic [1:0] DIV_SCALE = 2'd0;
   localparam logic [1:0] DIV_PER_X = 2'd1;
   localparam logic [1:0] DIV_PER_Y = 2'd2;

   typedef struct packed {
      logic       capture;
      logic       apply;
      logic       sq_x;
      logic       sq_y;
      logic       sqrt_load;
      logic       sqrt_step;
      logic       div_load;
      logic [1:0] div_sel;
      logic       div_step;
      logic       mul;
      logic       set_rate;
      logic       set_per_x;
      logic       set_per_y;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic is_speed;
      logic span_zero;
   } status_type;

endpackage

/* hw/rtl/xysm_datapath.sv */
// Datapath of the stepper controller: axis state, configuration registers,
// square root, shared divider, rate clamp and the result register. Uses xysm_pkg.
`timescale 1ns / 1ps

module xysm_datapath #(
   parameter int POS_BITS = xysm_pkg::POS_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  xysm_pkg::cmd_type                   cmd,
   output xysm_pkg::status_type                status,
   input  logic [xysm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [1:0]                          req_tuser,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [xysm_pkg::RATE_W-1:0]         csr_wdata,
   output logic [xysm_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import xysm_pkg::*;

   localparam int P      = POS_BITS;
   localparam int RW     = 2 * P + 2;
   localparam int DW     = (P > RATE_W) ? P : RATE_W;
   localparam int RAW_W  = P + 1 + DIV_NUM_W;

   typedef struct packed {
      logic [P-1:0] pos;
      logic         pulse;
      logic         dir;
   } axis_type;

   function automatic axis_type move_axis(axis_type a, logic [P-1:0] goal,
                                          logic [P-1:0] span, logic sw_lo,
                                          logic sw_hi);
      axis_type r;
      r = a;
      if (goal > a.pos) begin
         if (!sw_hi) begin
            r.dir = 1'b1;
            if (a.pos < span) begin
               r.pos   = a.pos + 1'b1;
               r.pulse = ~a.pulse;
            end
         end
      end else if (goal < a.pos) begin
         if (!sw_lo) begin
            r.dir = 1'b0;
            if (a.pos != '0) begin
               r.pos   = a.pos - 1'b1;
               r.pulse = ~a.pulse;
            end
         end
      end
      return r;
   endfunction

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_X_UP   = 3'd1;
   localparam logic [2:0] PH_X_DOWN = 3'd2;
   localparam logic [2:0] PH_Y_UP   = 3'd3;
   localparam logic [2:0] PH_Y_DOWN = 3'd4;

   // Captured request word.
   logic [1:0]  cmd_code_ff;
   logic [REQ_DATA_W-1:0] in_ff;
   logic        tick_x, tick_y, sw_xl, sw_xh, sw_yl, sw_yh;
   logic [RATE_W-1:0] new_x, new_y;

   // Configuration.
   logic [RATE_W-1:0] x_max_ff, x_min_ff, y_max_ff, y_min_ff;

   // Axis state.
   axis_type    ax_ff, ax_in, ay_ff, ay_in;
   logic [P-1:0] goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [P-1:0] span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic        done_ff, done_in;
   logic [2:0]  phase_ff, phase_in;

   // Speed arithmetic.
   logic [P-1:0]    dx, dy;
   logic [2*P-1:0]  sq_ff;
   logic [2*P:0]    sum_ff;
   logic [RW-1:0]   rad_ff;
   logic [P:0]      root_ff;
   logic [P+1:0]    rem_ff;
   logic [P+3:0]    sq_trial_t, sq_trial_d;
   logic [DIV_NUM_W-1:0] num_ff, quo_ff;
   logic [DW-1:0]   den_ff, drem_ff;
   logic [DW:0]     div_t;
   logic [RAW_W-1:0] raw_ff;
   logic [RATE_W-1:0] rate_x_ff, rate_y_ff;
   logic [PERIOD_W-1:0] per_x_ff, per_y_ff;
   logic [RSP_DATA_W-1:0] out_ff;

   assign tick_x = in_ff[0];
   assign tick_y = in_ff[1];
   assign new_x  = in_ff[17:2];
   assign new_y  = in_ff[33:18];
   assign sw_xl  = in_ff[34];
   assign sw_xh  = in_ff[35];
   assign sw_yl  = in_ff[36];
   assign sw_yh  = in_ff[37];

   assign status.is_speed  = (cmd_code_ff == CMD_SPEED);
   assign status.span_zero = (span_x_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_code_ff <= req_tuser;
         in_ff       <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_max_ff <= X_RATE_MAX_RST;
         x_min_ff <= X_RATE_MIN_RST;
         y_max_ff <= Y_RATE_MAX_RST;
         y_min_ff <= Y_RATE_MIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_X_RATE_MAX: x_max_ff <= csr_wdata;
            CSR_X_RATE_MIN: x_min_ff <= csr_wdata;
            CSR_Y_RATE_MAX: y_max_ff <= csr_wdata;
            CSR_Y_RATE_MIN: y_min_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Command execution for tick, set target and start homing.
   always_comb begin
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      goal_x_in = goal_x_ff;
      goal_y_in = goal_y_ff;
      span_x_in = span_x_ff;
      span_y_in = span_y_ff;
      done_in   = done_ff;
      phase_in  = phase_ff;
      if (cmd.apply) begin
         unique case (cmd_code_ff)
            CMD_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  case (phase_ff)
                     PH_X_UP: begin
                        if (tick_x) begin
                           if (sw_xh) begin
                              phase_in = PH_X_DOWN;
                           end else begin
                              ax_in.pulse = ~ax_ff.pulse;
                              ax_in.dir   = 1'b1;
                           end
                        end
                     end
                     PH_X_DOWN: begin
                        if (tick_x) begin
                           if (sw_xl) begin
                              phase_in = PH_Y_UP;
                           end else begin
                              ax_in.pulse = ~ax_ff.pulse;
                              ax_in.dir   = 1'b0;
                              if (span_x_ff != '1) span_x_in = span_x_ff + 1'b1;
                           end
                        end
                     end
                     PH_Y_UP: begin
                        if (tick_y) begin
                           if (sw_yh) begin
                              phase_in = PH_Y_DOWN;
                           end else begin
                              ay_in.pulse = ~ay_ff.pulse;
                              ay_in.dir   = 1'b1;
                           end
                        end
                     end
                     PH_Y_DOWN: begin
                        if (tick_y) begin
                           if (sw_yl) begin
                              ax_in.pos = '0;
                              ay_in.pos = '0;
                              done_in   = 1'b1;
                              phase_in  = PH_IDLE;
                           end else begin
                              ay_in.pulse = ~ay_ff.pulse;
                              ay_in.dir   = 1'b0;
                              if (span_y_ff != '1) span_y_in = span_y_ff + 1'b1;
                           end
                        end
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end else if (done_ff) begin
                  if (tick_x) ax_in = move_axis(ax_ff, goal_x_ff, span_x_ff, sw_xl, sw_xh);
                  if (tick_y) ay_in = move_axis(ay_ff, goal_y_ff, span_y_ff, sw_yl, sw_yh);
               end
            end
            CMD_TARGET: begin
               if ((DW'(new_x) <= DW'(span_x_ff)) && (DW'(new_y) <= DW'(span_y_ff))) begin
                  goal_x_in = P'(new_x);
                  goal_y_in = P'(new_y);
               end
            end
            CMD_HOME: begin
               span_x_in = '0;
               span_y_in = '0;
               done_in   = 1'b0;
               phase_in  = PH_X_UP;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff     <= '0;
         ay_ff     <= '0;
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         span_x_ff <= '0;
         span_y_ff <= '0;
         done_ff   <= 1'b0;
         phase_ff  <= PH_IDLE;
      end else begin
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
         goal_x_ff <= goal_x_in;
         goal_y_ff <= goal_y_in;
         span_x_ff <= span_x_in;
         span_y_ff <= span_y_in;
         done_ff   <= done_in;
         phase_ff  <= phase_in;
      end
   end

   // Distance: dx squared, then dy squared and summed, then a two-bits-per-cycle square root.
   assign dx = (ax_ff.pos > goal_x_ff) ? ax_ff.pos - goal_x_ff : goal_x_ff - ax_ff.pos;
   assign dy = (ay_ff.pos > goal_y_ff) ? ay_ff.pos - goal_y_ff : goal_y_ff - ay_ff.pos;

   assign sq_trial_t = {rem_ff, rad_ff[RW-1:RW-2]};
   assign sq_trial_d = (P+4)'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (cmd.sq_x) sq_ff <= dx * dx;
      if (cmd.sq_y) sum_ff <= {1'b0, sq_ff} + (2*P+1)'(dy * dy);
      if (cmd.sqrt_load) begin
         rad_ff  <= RW'(sum_ff);
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= {rad_ff[RW-3:0], 2'b00};
         if (sq_trial_t >= sq_trial_d) begin
            rem_ff  <= (P+2)'(sq_trial_t - sq_trial_d);
            root_ff <= {root_ff[P-1:0], 1'b1};
         end else begin
            rem_ff  <= (P+2)'(sq_trial_t);
            root_ff <= {root_ff[P-1:0], 1'b0};
         end
      end
   end

   // Shared restoring divider, one quotient bit per cycle.
   assign div_t = {drem_ff, num_ff[DIV_NUM_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         drem_ff <= '0;
         quo_ff  <= '0;
         case (cmd.div_sel)
            DIV_SCALE: begin
               num_ff <= DIV_NUM_W'(x_max_ff) * SPEED_SLOPE;
               den_ff <= DW'(span_x_ff);
            end
            DIV_PER_X: begin
               num_ff <= US_PER_SECOND;
               den_ff <= (rate_x_ff == '0) ? DW'(1) : DW'(rate_x_ff);
            end
            default: begin
               num_ff <= US_PER_SECOND;
               den_ff <= (rate_y_ff == '0) ? DW'(1) : DW'(rate_y_ff);
            end
         endcase
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[DIV_NUM_W-2:0], 1'b0};
         if (div_t >= {1'b0, den_ff}) begin
            drem_ff <= DW'(div_t - {1'b0, den_ff});
            quo_ff  <= {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            drem_ff <= DW'(div_t);
            quo_ff  <= {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
      end
      if (cmd.mul) raw_ff <= root_ff * quo_ff;
   end

   // Rate clamp; a zero X span forces both axes to their max rate.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_x_ff <= '0;
         rate_y_ff <= '0;
         per_x_ff  <= PERIOD_W'(US_PER_SECOND);
         per_y_ff  <= PERIOD_W'(US_PER_SECOND);
      end else begin
         if (cmd.set_rate) begin
            if (status.span_zero || raw_ff >= RAW_W'(x_max_ff)) rate_x_ff <= x_max_ff;
            else if (raw_ff < RAW_W'(x_min_ff)) rate_x_ff <= x_min_ff;
            else rate_x_ff <= RATE_W'(raw_ff);
            if (status.span_zero || raw_ff >= RAW_W'(y_max_ff)) rate_y_ff <= y_max_ff;
            else if (raw_ff < RAW_W'(y_min_ff)) rate_y_ff <= y_min_ff;
            else rate_y_ff <= RATE_W'(raw_ff);
         end
         if (cmd.set_per_x) per_x_ff <= PERIOD_W'(quo_ff);
         if (cmd.set_per_y) per_y_ff <= PERIOD_W'(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff <= {2'b00, per_y_ff, per_x_ff, (phase_ff != PH_IDLE), done_ff,
                    16'(span_y_ff), 16'(span_x_ff), 16'(ay_ff.pos), 16'(ax_ff.pos),
                    ay_ff.dir, ay_ff.pulse, ax_ff.dir, ax_ff.pulse};
      end
   end

   assign rsp_tdata = out_ff;

endmodule

/* hw/rtl/xysm_ctrl.sv */
// Sequencer of the stepper controller: handshakes and step-by-step commands
// to xysm_datapath for the speed computation. Uses xysm_pkg.
`timescale 1ns / 1ps

module xysm_ctrl #(
   parameter int POS_BITS = xysm_pkg::POS_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output xysm_pkg::cmd_type     cmd,
   input  xysm_pkg::status_type  status
);
   import xysm_pkg::*;

   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(POS_BITS);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_NUM_W - 1);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_EXEC = 5'd1;
   localparam logic [4:0] S_SQX  = 5'd2;
   localparam logic [4:0] S_SQY  = 5'd3;
   localparam logic [4:0] S_RTL  = 5'd4;
   localparam logic [4:0] S_RTS  = 5'd5;
   localparam logic [4:0] S_DSL  = 5'd6;
   localparam logic [4:0] S_DSS  = 5'd7;
   localparam logic [4:0] S_MUL  = 5'd8;
   localparam logic [4:0] S_RATE = 5'd9;
   localparam logic [4:0] S_DXL  = 5'd10;
   localparam logic [4:0] S_DXS  = 5'd11;
   localparam logic [4:0] S_DYL  = 5'd12;
   localparam logic [4:0] S_DYS  = 5'd13;
   localparam logic [4:0] S_PY   = 5'd14;
   localparam logic [4:0] S_OUT  = 5'd15;

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.apply = 1'b1;
            state_in  = status.is_speed ? S_SQX : S_OUT;
         end
         S_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = S_RTL;
         end
         S_RTL: begin
            cmd.sqrt_load = 1'b1;
            cnt_in        = '0;
            state_in      = S_RTS;
         end
         S_RTS: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) state_in = status.span_zero ? S_RATE : S_DSL;
         end
         S_DSL: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = DIV_SCALE;
            cnt_in       = '0;
            state_in     = S_DSS;
         end
         S_DSS: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_RATE;
         end
         S_RATE: begin
            cmd.set_rate = 1'b1;
            state_in     = S_DXL;
         end
         S_DXL: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = DIV_PER_X;
            cnt_in       = '0;
            state_in     = S_DXS;
         end
         S_DXS: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_DYL;
         end
         S_DYL: begin
            cmd.set_per_x = 1'b1;
            cmd.div_load  = 1'b1;
            cmd.div_sel   = DIV_PER_Y;
            cnt_in        = '0;
            state_in      = S_DYS;
         end
         S_DYS: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_PY;
         end
         S_PY: begin
            cmd.set_per_y = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

/* hw/rtl/xy_stepper_motion_controller_core.sv */
// Top level of the two-axis stepper homing and position controller.
// Joins xysm_ctrl and xysm_datapath; uses xysm_pkg.
`timescale 1ns / 1ps
//
// Every request word carries one command in req_tuser and yields exactly one
// response word on the rsp_ channel, in order. Commands are tick, set target,
// start homing and recompute speed. The csr_ port writes the four rate
// registers; write them only while no word is in flight.
//
// A tick, set-target or homing command is executed and then loaded into the
// response register. A speed command goes on to square the distances and take
// the square root, which produces one root bit per cycle; the shared restoring
// divider then produces one quotient bit per cycle, and it runs three times in
// turn (speed scale, X period, Y period), with the multiply and rate clamp
// after the scale division. With a zero X span the scale division and the
// multiply are skipped.
// One word is worked on at a time. req_tready is high while the sequencer is
// idle, also while a finished response still waits in the output register;
// a stalled receiver only holds the sequencer when the next response is due.
//
// Reset clears positions, goals, spans, flags and rates, restores the rate
// registers to 2000/100 Hz and sets both periods to one second.

module xy_stepper_motion_controller_core #(
   parameter int POS_BITS = xysm_pkg::POS_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: tick_x, tick_y, new_x[15:0], new_y[15:0], sw_x_low, sw_x_high,
   // sw_y_low, sw_y_high, then two zero bits.
   input  logic [xysm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: command[1:0].
   input  logic [1:0]                       req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: x_step_pin, x_dir_pin, y_step_pin, y_dir_pin, x_position[15:0],
   // y_position[15:0], x_span[15:0], y_span[15:0], calibrated, calibrating,
   // x_period_us[19:0], y_period_us[19:0], then two zero bits.
   output logic [xysm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [xysm_pkg::RATE_W-1:0]      csr_wdata
);
   import xysm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The sequencer owns both handshakes and walks the datapath through a word.
   xysm_ctrl #(
      .POS_BITS (POS_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // All axis state, configuration, arithmetic and the response register live in the datapath.
   xysm_datapath #(
      .POS_BITS (POS_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
